// ===== src/sft_pkg.sv =====
// Shared types, constants and coefficient ROM for the stereo FIR tone selector.
package sft_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int TAPS        = 81;
    localparam int HIST_DEPTH  = TAPS - 1;
    localparam int FILTER_SETS = 3;
    localparam int MODE_W      = 3;
    localparam int ACC_W       = 32;
    localparam int SET_W       = $clog2(FILTER_SETS);
    localparam int K_W         = $clog2(TAPS);

    localparam logic [MODE_W-1:0] MODE_PASS = 3'd0;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_FILT,
        OP_MUTE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        t_op                           op;
        logic [SET_W-1:0]              set;
    } t_item;

    localparam logic signed [COEF_BITS-1:0] COEF_ROM [FILTER_SETS][TAPS] = '{
        '{ 0, 3, 6, 9, 11, 13, 13, 12, 9, 4,
           -2, -10, -19, -28, -36, -42, -46, -45, -38, -23,
           0, 33, 78, 134, 202, 282, 373, 475, 585, 702,
           823, 946, 1068, 1185, 1294, 1392, 1477, 1546, 1597, 1628,
           1638,
           1628, 1597, 1546, 1477, 1392, 1294, 1185, 1068, 946, 823,
           702, 585, 475, 373, 282, 202, 134, 78, 33, 0,
           -23, -38, -45, -46, -42, -36, -28, -19, -10, -2,
           4, 9, 12, 13, 13, 11, 9, 6, 3, 0 },
        '{ 0, 10, 13, 5, -11, -26, -29, -21, -9, -1,
           0, 3, 19, 49, 80, 85, 46, -25, -84, -82,
           0, 117, 173, 74, -202, -563, -834, -851, -585, -199,
           0, -269, -1068, -2125, -2893, -2785, -1477, 862, 3571, 5730,
           6554,
           5730, 3571, 862, -1477, -2785, -2893, -2125, -1068, -269, 0,
           -199, -585, -851, -834, -563, -202, 74, 173, 117, 0,
           -82, -84, -25, 46, 85, 80, 49, 19, 3, 0,
           -1, -9, -21, -29, -26, -11, 5, 13, 10, 0 },
        '{ 0, -13, -19, -14, 0, 13, 16, 9, 0, -3,
           2, 7, 0, -22, -44, -42, 0, 69, 122, 105,
           0, -150, -251, -208, 0, 282, 461, 377, 0, -503,
           -823, -677, 0, 940, 1599, 1392, 0, -2408, -5168, -7358,
           24576,
           -7358, -5168, -2408, 0, 1392, 1599, 940, 0, -677, -823,
           -503, 0, 377, 461, 282, 0, -208, -251, -150, 0,
           105, 122, 69, 0, -42, -44, -22, 0, 7, 2,
           -3, 0, 9, 16, 13, 0, -14, -19, -13, 0 }
    };

endpackage

// ===== src/sft_front.sv =====
// Front end: mode register, input beat capture and classification.
module sft_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [sft_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [sft_pkg::SAMPLE_BITS-1:0] i_right_sample,
    input  logic                                   i_cfg_we,
    input  logic [sft_pkg::MODE_W-1:0]             i_cfg_data,
    output logic                                   o_push,
    output sft_pkg::t_item                         o_item,
    input  logic                                   i_q_ready
);
    import sft_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic              r_vld;
    logic              n_vld;
    t_item             r_item;
    t_item             n_item;
    logic              accept;

    assign o_stall = r_vld && !i_q_ready;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_item       = r_item;
        n_item.left  = i_left_sample;
        n_item.right = i_right_sample;
        n_item.set   = '0;
        if (r_mode == MODE_PASS) begin
            n_item.op = OP_PASS;
        end else if (r_mode <= MODE_W'(FILTER_SETS)) begin
            n_item.op  = OP_FILT;
            n_item.set = SET_W'(r_mode - 1'b1);
        end else begin
            n_item.op = OP_MUTE;
        end
    end

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (i_q_ready) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/sft_queue.sv =====
// Short item queue between the front end and the filter engine.
module sft_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sft_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_vld,
    output sft_pkg::t_item o_item,
    input  logic           i_pop
);
    import sft_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== src/sft_back.sv =====
// Filter engine: sample history memories, pipelined MAC and output register.
module sft_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_vld,
    input  sft_pkg::t_item                         i_q_item,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [sft_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [sft_pkg::SAMPLE_BITS-1:0] o_right_out
);
    import sft_pkg::*;

    localparam int HIST_W = $clog2(HIST_DEPTH);
    localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
    localparam int CMP_W  = (K_W > CNT_W) ? K_W : CNT_W;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int FRAC   = COEF_BITS - 1;
    localparam int Q_W    = PROD_W + 1 - FRAC;
    localparam int BIAS   = (1 << FRAC) - 1;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic signed [Q_W-1:0] trunc_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        t = {p[PROD_W-1], p} + (p[PROD_W-1] ? (PROD_W+1)'(BIAS) : (PROD_W+1)'(0));
        return t[PROD_W:FRAC];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [Q_W-1:0] q);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-Q_W){q[Q_W-1]}}, q};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] l_mem [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_mem [HIST_DEPTH];

    t_state                  r_state;
    t_state                  n_state;
    t_item                   r_cur;
    logic [HIST_W-1:0]       r_wp;
    logic [CNT_W-1:0]        r_cnt;
    logic [K_W-1:0]          r_k;
    logic [HIST_W-1:0]       r_raddr;
    logic signed [SAMPLE_BITS-1:0] r_lrd;
    logic signed [SAMPLE_BITS-1:0] r_rrd;
    logic                    r_p1_vld;
    logic [K_W-1:0]          r_p1_k;
    logic                    r_p1_cur;
    logic                    r_p1_live;
    logic                    r_p2_vld;
    logic signed [PROD_W-1:0] r_lprod;
    logic signed [PROD_W-1:0] r_rprod;
    logic signed [ACC_W-1:0] r_lacc;
    logic signed [ACC_W-1:0] r_racc;
    logic                    r_ovld;
    logic signed [SAMPLE_BITS-1:0] r_lout;
    logic signed [SAMPLE_BITS-1:0] r_rout;

    logic                    pop;
    logic                    issue;
    logic                    fin;
    logic                    out_free;
    logic                    live;
    logic signed [SAMPLE_BITS-1:0] x_l;
    logic signed [SAMPLE_BITS-1:0] x_r;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] cur_l;
    logic signed [SAMPLE_BITS-1:0] cur_r;
    logic signed [SAMPLE_BITS-1:0] n_lout;
    logic signed [SAMPLE_BITS-1:0] n_rout;
    logic [HIST_W-1:0]       wp_prev;

    assign out_free = !r_ovld || !i_stall;
    assign o_pop    = pop;
    assign o_valid  = r_ovld;
    assign o_left_out  = r_lout;
    assign o_right_out = r_rout;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_vld) begin
                    n_state = (i_q_item.op == OP_FILT) ? ST_MAC : ST_DONE;
                end
            end
            ST_MAC: begin
                if (r_k == K_W'(TAPS - 1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        fin   = 1'b0;
        case (r_state)
            ST_IDLE:  pop   = i_q_vld;
            ST_MAC:   issue = 1'b1;
            ST_FLUSH: ;
            ST_DONE:  fin   = out_free;
            default: ;
        endcase
    end

    assign wp_prev = (r_wp == '0) ? HIST_W'(HIST_DEPTH - 1) : r_wp - 1'b1;
    assign live    = (r_k != '0) && (CMP_W'(r_k) <= CMP_W'(r_cnt));
    assign cur_l   = r_cur.left;
    assign cur_r   = r_cur.right;
    assign x_l     = r_p1_cur ? cur_l : (r_p1_live ? r_lrd : '0);
    assign x_r     = r_p1_cur ? cur_r : (r_p1_live ? r_rrd : '0);
    assign coef    = COEF_ROM[r_cur.set][r_p1_k];

    always_comb begin
        case (r_cur.op)
            OP_PASS: begin
                n_lout = cur_l;
                n_rout = cur_r;
            end
            OP_FILT: begin
                n_lout = r_lacc[SAMPLE_BITS-1:0];
                n_rout = r_racc[SAMPLE_BITS-1:0];
            end
            default: begin
                n_lout = '0;
                n_rout = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            if (fin) begin
                r_wp <= (r_wp == HIST_W'(HIST_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_cnt != CNT_W'(HIST_DEPTH)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (fin) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur   <= i_q_item;
            r_k     <= '0;
            r_raddr <= wp_prev;
        end else if (issue) begin
            r_k <= K_W'(r_k + 1'b1);
            if (r_k != '0) begin
                r_raddr <= (r_raddr == '0) ? HIST_W'(HIST_DEPTH - 1) : r_raddr - 1'b1;
            end
        end
        r_p1_k    <= r_k;
        r_p1_cur  <= (r_k == '0);
        r_p1_live <= live;
        r_lprod   <= PROD_W'(x_l) * PROD_W'(coef);
        r_rprod   <= PROD_W'(x_r) * PROD_W'(coef);
        if (pop) begin
            r_lacc <= '0;
            r_racc <= '0;
        end else if (r_p2_vld) begin
            r_lacc <= sat_add(r_lacc, trunc_q(r_lprod));
            r_racc <= sat_add(r_racc, trunc_q(r_rprod));
        end
        if (fin) begin
            r_lout <= n_lout;
            r_rout <= n_rout;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lrd <= l_mem[r_raddr];
        r_rrd <= r_mem[r_raddr];
        if (fin) begin
            l_mem[r_wp] <= cur_l;
            r_mem[r_wp] <= cur_r;
        end
    end

endmodule

// ===== src/stereo_fir_tone_selector.sv =====
// Top level of the stereo FIR tone selector.
// Pass-through and mute beats pass from the front-end register through the queue to the
// engine's output register; filtered beats first run the MAC pipeline (history read,
// product, accumulate). The engine takes one queued pair at a time: a filtered pair gets
// one MAC pass per tap over both history memories; pass and mute pairs skip the MAC.
// Reset clears the mode to pass-through, empties the queue and zeroes the history fill.
module stereo_fir_tone_selector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [sft_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [sft_pkg::SAMPLE_BITS-1:0] i_right_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [sft_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [sft_pkg::SAMPLE_BITS-1:0] o_right_out,
    input  logic                                   i_cfg_we,
    input  logic [sft_pkg::MODE_W-1:0]             i_cfg_data
);
    import sft_pkg::*;

    logic  f_push;
    t_item f_item;
    logic  q_ready;
    logic  q_vld;
    t_item q_item;
    logic  b_pop;

    sft_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_push         (f_push),
        .o_item         (f_item),
        .i_q_ready      (q_ready)
    );

    sft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .i_pop   (b_pop)
    );

    sft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_item    (q_item),
        .o_pop       (b_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule

// ===== src/sft_checker.sv =====
// Port-level assertions for the stereo FIR tone selector, bound to the top level.
module sft_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [sft_pkg::SAMPLE_BITS-1:0] o_left_out,
    input logic signed [sft_pkg::SAMPLE_BITS-1:0] o_right_out,
    input logic                                   i_cfg_we,
    input logic [sft_pkg::MODE_W-1:0]             i_cfg_data
);
    import sft_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [7:0]        r_pend;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_pend <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (in_acc && !out_acc) begin
                r_pend <= r_pend + 1'b1;
            end else if (out_acc && !in_acc) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not quiet after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_out)
            && $stable(o_right_out))
        else $error("stalled result beat changed");

    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_mode > MODE_W'(FILTER_SETS)) |->
            (o_left_out == '0) && (o_right_out == '0))
        else $error("muted beat not zero");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("result beat without an accepted input beat");

endmodule

bind stereo_fir_tone_selector sft_checker u_sft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data)
);
